/* rtl/core/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants of the running statistics accumulator.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int CNT_W  = 32;
  localparam int SUM_W  = 64;
  localparam int SMP_W  = 32;
  localparam int MEAN_W = 48;
  localparam int FRAC_W = 16;
  localparam int DIFF_W = MEAN_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W   = 63;
  localparam int MASK_W = 4;
  localparam int OUT_W  = 272;

  localparam int MASK_SUM = 0;
  localparam int MASK_MAX = 1;
  localparam int MASK_MIN = 2;
  localparam int MASK_VAR = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DIV,
    ST_MSTART,
    ST_MUL,
    ST_HOLD
  } state_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* rtl/core/rsa_div.sv */
// ----------------------------------------------------------------------------
// rsa_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsa_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUM_W-1:0]       dividend,
  input  logic [DEN_W-1:0]       divisor,
  output rsa_pkg::unit_stat_t    stat,
  output logic [NUM_W-1:0]       quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign shifted = {rem, quo[NUM_W-1]};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? DEN_W'(shifted - {1'b0, divisor}) : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

/* rtl/core/rsa_mul.sv */
// ----------------------------------------------------------------------------
// rsa_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rsa_mul #(
  parameter int OP_W = 49
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [OP_W-1:0]       mcand,
  input  logic [OP_W-1:0]       mplier,
  output rsa_pkg::unit_stat_t   stat,
  output logic [2*OP_W-1:0]     product
);

  localparam int CW = $clog2(OP_W + 1);

  logic [2*OP_W-1:0] acc;
  logic [OP_W-1:0]   cand;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;
  logic [OP_W:0]     part;

  assign part = {1'b0, acc[2*OP_W-1:OP_W]} + (acc[0] ? {1'b0, cand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(OP_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= {{OP_W{1'b0}}, mplier};
      cand <= mcand;
    end else if (busy) begin
      acc <= {part, acc[OP_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = acc;

endmodule

/* rtl/core/running_statistics_accumulator.sv */
// ----------------------------------------------------------------------------
// running_statistics_accumulator
// Count, sum, min, max and Welford mean / squared-deviation sum per sample.
// ----------------------------------------------------------------------------
// One sample per transaction, one result per sample. Count, sum, min and max
// update in the accept cycle. With the variance enable clear, the result is
// ready in the next cycle, and a new sample is taken in the cycle the result
// drains. With the enable set, the mean step runs through a bit-serial divider
// and the deviation product through a bit-serial multiplier, divider first,
// each from its own start state. The result is registered from the hold state
// once the output register is free, and the block then returns to idle.
// One item is processed at a time. The next is taken once the block is idle
// and the output register is free or being drained.
module running_statistics_accumulator #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_data,      // compute_mask
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [31:0]    s_tdata,       // sample_value
  output logic           m_tvalid,
  input  logic           m_tready,
  // sample_count, running_sum, running_min, running_max, running_mean,
  // squared_dev_sum, one zero pad bit
  output logic [271:0]   m_tdata
);

  localparam int SB    = (SAMPLE_WIDTH < rsa_pkg::SMP_W) ? SAMPLE_WIDTH : rsa_pkg::SMP_W;
  localparam int SHIFT = rsa_pkg::SMP_W - SB;
  localparam int DW    = rsa_pkg::DIFF_W;
  localparam int PW    = rsa_pkg::PROD_W;
  localparam int SQW   = rsa_pkg::SQ_W;

  rsa_pkg::state_t state, state_next;

  logic [rsa_pkg::MASK_W-1:0]        mask;
  logic [rsa_pkg::CNT_W-1:0]         count_reg, count_next;
  logic signed [rsa_pkg::SUM_W-1:0]  sum_reg, sum_next;
  logic signed [rsa_pkg::SMP_W-1:0]  min_reg, min_next, max_reg, max_next;
  logic signed [rsa_pkg::MEAN_W-1:0] mean_reg, mean_next;
  logic [SQW-1:0]                    sqdev_reg, sqdev_next;

  logic signed [rsa_pkg::MEAN_W-1:0] xq;
  logic [DW-1:0]                     mag1;
  logic                              neg1;

  logic accept, out_free;
  logic div_start, mul_start;
  rsa_pkg::unit_stat_t div_stat, mul_stat;
  logic [DW-1:0] quo;
  logic [PW-1:0] prod;

  logic signed [rsa_pkg::SMP_W-1:0]  xs;
  logic signed [rsa_pkg::MEAN_W-1:0] xq_in;
  logic signed [DW-1:0]              d1, d2;
  logic [DW-1:0]                     mag2;
  logic signed [rsa_pkg::SUM_W:0]    sum_ext;
  logic [SQW-1:0]                    p_sat;
  logic [SQW:0]                      sq_ext;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  assign xs    = $signed(s_tdata << SHIFT) >>> SHIFT;
  assign xq_in = {xs, {rsa_pkg::FRAC_W{1'b0}}};
  assign d1    = DW'(xq_in) - DW'(mean_reg);
  assign sum_ext = {sum_reg[rsa_pkg::SUM_W-1], sum_reg}
                 + {{(rsa_pkg::SUM_W - rsa_pkg::SMP_W + 1){xs[rsa_pkg::SMP_W-1]}}, xs};

  // second deviation against the already updated mean
  assign d2   = DW'(xq) - DW'(mean_reg);
  assign mag2 = d2[DW-1] ? DW'(-d2) : DW'(d2);

  assign p_sat  = (|prod[PW-1:SQW+rsa_pkg::FRAC_W]) ? {SQW{1'b1}}
                                                   : prod[SQW+rsa_pkg::FRAC_W-1:rsa_pkg::FRAC_W];
  assign sq_ext = {1'b0, sqdev_reg} + {1'b0, p_sat};

  always_comb begin
    count_next = count_reg;
    sum_next   = sum_reg;
    min_next   = min_reg;
    max_next   = max_reg;
    mean_next  = mean_reg;
    sqdev_next = sqdev_reg;
    if (accept) begin
      if (count_reg != {rsa_pkg::CNT_W{1'b1}}) count_next = count_reg + 1'b1;
      if (mask[rsa_pkg::MASK_SUM]) begin
        if (sum_ext[rsa_pkg::SUM_W] != sum_ext[rsa_pkg::SUM_W-1])
          sum_next = sum_ext[rsa_pkg::SUM_W] ? {1'b1, {(rsa_pkg::SUM_W-1){1'b0}}}
                                             : {1'b0, {(rsa_pkg::SUM_W-1){1'b1}}};
        else
          sum_next = sum_ext[rsa_pkg::SUM_W-1:0];
      end
      if (mask[rsa_pkg::MASK_MAX] && xs > max_reg) max_next = xs;
      if (mask[rsa_pkg::MASK_MIN] && xs < min_reg) min_next = xs;
    end
    if (div_stat.done)
      mean_next = neg1 ? mean_reg - rsa_pkg::MEAN_W'(quo) : mean_reg + rsa_pkg::MEAN_W'(quo);
    if (mul_stat.done)
      sqdev_next = sq_ext[SQW] ? {SQW{1'b1}} : sq_ext[SQW-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rsa_pkg::ST_IDLE: begin
        if (accept && mask[rsa_pkg::MASK_VAR]) state_next = rsa_pkg::ST_DSTART;
      end
      rsa_pkg::ST_DSTART: state_next = rsa_pkg::ST_DIV;
      rsa_pkg::ST_DIV:    if (div_stat.done) state_next = rsa_pkg::ST_MSTART;
      rsa_pkg::ST_MSTART: state_next = rsa_pkg::ST_MUL;
      rsa_pkg::ST_MUL:    if (mul_stat.done) state_next = rsa_pkg::ST_HOLD;
      rsa_pkg::ST_HOLD:   if (out_free) state_next = rsa_pkg::ST_IDLE;
      default:            state_next = rsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    unique case (state)
      rsa_pkg::ST_IDLE:   s_tready  = out_free;
      rsa_pkg::ST_DSTART: div_start = 1'b1;
      rsa_pkg::ST_MSTART: mul_start = 1'b1;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rsa_pkg::ST_IDLE;
      mask      <= '0;
      count_reg <= '0;
      sum_reg   <= '0;
      min_reg   <= {1'b0, {(rsa_pkg::SMP_W-1){1'b1}}};
      max_reg   <= {1'b1, {(rsa_pkg::SMP_W-1){1'b0}}};
      mean_reg  <= '0;
      sqdev_reg <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      if (cfg_valid && cfg_ready) mask <= cfg_data;
      count_reg <= count_next;
      sum_reg   <= sum_next;
      min_reg   <= min_next;
      max_reg   <= max_next;
      mean_reg  <= mean_next;
      sqdev_reg <= sqdev_next;
      if ((accept && !mask[rsa_pkg::MASK_VAR]) || (state == rsa_pkg::ST_HOLD && out_free))
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xq   <= xq_in;
      neg1 <= d1[DW-1];
      mag1 <= d1[DW-1] ? DW'(-d1) : DW'(d1);
    end
    if ((accept && !mask[rsa_pkg::MASK_VAR]) || (state == rsa_pkg::ST_HOLD && out_free))
      m_tdata <= {1'b0, sqdev_next, mean_next, max_next, min_next, sum_next, count_next};
  end

  rsa_div #(.NUM_W(DW), .DEN_W(rsa_pkg::CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag1),
    .divisor  (count_reg),
    .stat     (div_stat),
    .quotient (quo)
  );

  rsa_mul #(.OP_W(DW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mag1),
    .mplier  (mag2),
    .stat    (mul_stat),
    .product (prod)
  );

`ifndef SYNTH
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == rsa_pkg::ST_DIV) else $error("divider done outside DIV");
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> state == rsa_pkg::ST_MUL) else $error("multiplier done outside MUL");
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    accept |=> count_reg != '0) else $error("count zero after a sample");
`endif

endmodule
